// ===== rtl/kpd_pkg.sv =====
// ----------------------------------------------------------------------------
// kpd_pkg
// shared constants, types and key map of the keypad scanner
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

  localparam int NUM_COLUMNS = 4;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_KEYS    = NUM_COLUMNS * NUM_ROWS;
  localparam int COUNT_WIDTH = 8;
  localparam int COL_WIDTH   = $clog2(NUM_COLUMNS);
  localparam int ROW_WIDTH   = $clog2(NUM_ROWS);
  localparam int KEY_WIDTH   = $clog2(NUM_KEYS);
  localparam int THR_WIDTH   = 8;
  localparam int CHAR_WIDTH  = 7;
  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;

  localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET = 8'd2;
  localparam logic                 REG_THRESHOLD   = 1'b0;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [NUM_ROWS-1:0]          ack;
    logic [NUM_ROWS-1:0][COUNT_WIDTH-1:0] cnt;
  } column_row_t;

  localparam logic [CHAR_WIDTH-1:0] KEY_MAP [NUM_KEYS] = '{
    7'h46, 7'h42, 7'h37, 7'h33, 7'h45, 7'h41, 7'h36, 7'h32,
    7'h44, 7'h39, 7'h35, 7'h31, 7'h43, 7'h38, 7'h34, 7'h30
  };

endpackage

`default_nettype wire

// ===== rtl/kpd_scan_if.sv =====
// ----------------------------------------------------------------------------
// kpd_scan_if
// scan tick channel: row levels of the driven column
// ----------------------------------------------------------------------------
`default_nettype none

interface kpd_scan_if;
  logic                         valid;
  logic                         ready;
  logic [kpd_pkg::NUM_ROWS-1:0] row_levels;

  modport source (output valid, output row_levels, input ready);
  modport sink   (input valid, input row_levels, output ready);
endinterface

`default_nettype wire

// ===== rtl/kpd_key_if.sv =====
// ----------------------------------------------------------------------------
// kpd_key_if
// key event channel: one item per accepted key or one empty item per tick
// ----------------------------------------------------------------------------
`default_nettype none

interface kpd_key_if;
  logic                           valid;
  logic                           ready;
  logic [kpd_pkg::COL_WIDTH-1:0]  next_column;
  logic                           key_valid;
  logic [kpd_pkg::KEY_WIDTH-1:0]  key_index;
  logic [kpd_pkg::CHAR_WIDTH-1:0] key_char;
  logic                           last;

  modport source (output valid, output next_column, output key_valid, output key_index,
                  output key_char, output last, input ready);
  modport sink   (input valid, input next_column, input key_valid, input key_index,
                  input key_char, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/keypad_scan_debounce.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_debounce
// 4x4 matrix keypad scanner with per-key held counters and debounce
//
//   channel  dir  handshake             payload
//   scan     in   valid/ready           row_levels
//   key      out  valid/ready           next_column key_valid key_index
//                                       key_char last
//   apb      in   psel/penable/pready   paddr pwdata prdata
//
// a scan item is read from the column memory on accept, updated and written
// back when the update stage moves on; one scan item per cycle when every tick gives one
// result and the key output is ready, otherwise the single key output sets the pace
// reset clears the column, the row valid bits and the stage valid bits and sets the threshold to 2
// a stalled key output holds the emitter, then the update stage, then scan
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_debounce (
  input  wire logic                             clk,
  input  wire logic                             rst,
  kpd_scan_if.sink                              scan,
  kpd_key_if.source                             key,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [kpd_pkg::PADDR_WIDTH-1:0]  paddr,
  input  wire logic [kpd_pkg::PDATA_WIDTH-1:0]  pwdata,
  output      logic [kpd_pkg::PDATA_WIDTH-1:0]  prdata,
  output      logic                             pready
);

  localparam int NR = kpd_pkg::NUM_ROWS;
  localparam int CW = kpd_pkg::COL_WIDTH;

  // configuration
  logic [kpd_pkg::THR_WIDTH-1:0] threshold;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == kpd_pkg::REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= kpd_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= pwdata[kpd_pkg::THR_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == kpd_pkg::REG_THRESHOLD) begin
      prdata = {{(kpd_pkg::PDATA_WIDTH-kpd_pkg::THR_WIDTH){1'b0}}, threshold};
    end
  end

  // column memory and handshake control
  kpd_pkg::column_row_t mem [kpd_pkg::NUM_COLUMNS];
  kpd_pkg::column_row_t rd_data;
  kpd_pkg::column_row_t wr_data;
  logic [kpd_pkg::NUM_COLUMNS-1:0] row_valid;

  logic [CW-1:0] scan_column;
  logic          s1_valid;
  logic [CW-1:0] s1_col;
  logic [NR-1:0] s1_rows;
  logic          s1_rdv;
  logic          s1_move;
  logic          scan_accept;

  logic          em_valid;
  logic [NR-1:0] em_mask;
  logic [CW-1:0] em_col;
  logic [CW-1:0] em_next;
  logic [NR-1:0] em_first;
  logic [NR-1:0] em_rest;
  logic          em_done;
  logic          key_accept;
  logic [NR-1:0] events;

  assign key_accept  = key.valid && key.ready;
  assign em_done     = key_accept && key.last;
  assign s1_move     = s1_valid && (!em_valid || em_done);
  assign scan.ready  = !s1_valid || s1_move;
  assign scan_accept = scan.valid && scan.ready;

  always_ff @(posedge clk) begin
    if (scan_accept) begin
      rd_data <= mem[scan_column];
    end
    if (s1_move) begin
      mem[s1_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column <= '0;
      s1_valid    <= 1'b0;
      row_valid   <= '0;
      em_valid    <= 1'b0;
    end else begin
      if (scan_accept) begin
        scan_column <= scan_column + 1'b1;
      end
      if (scan_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        row_valid[s1_col] <= 1'b1;
      end
      if (s1_move) begin
        em_valid <= 1'b1;
      end else if (em_done) begin
        em_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_accept) begin
      s1_col  <= scan_column;
      s1_rows <= scan.row_levels;
      s1_rdv  <= row_valid[scan_column];
    end
    if (s1_move) begin
      em_mask <= events;
      em_col  <= s1_col;
      em_next <= s1_col + 1'b1;
    end else if (key_accept) begin
      em_mask <= em_rest;
    end
  end

  // per-key counter update
  always_comb begin
    kpd_pkg::count_t old_cnt;
    kpd_pkg::count_t new_cnt;
    logic            old_ack;
    logic            over;
    wr_data = '0;
    events  = '0;
    for (int r = 0; r < NR; r++) begin
      old_cnt = s1_rdv ? rd_data.cnt[r] : '0;
      old_ack = s1_rdv ? rd_data.ack[r] : 1'b0;
      if (s1_rows[r]) begin
        new_cnt = '0;
      end else if (old_cnt != '1) begin
        new_cnt = old_cnt + 1'b1;
      end else begin
        new_cnt = old_cnt;
      end
      over             = new_cnt > threshold;
      wr_data.cnt[r]   = new_cnt;
      wr_data.ack[r]   = over;
      events[r]        = over && !old_ack;
    end
  end

  // result emitter
  logic [kpd_pkg::ROW_WIDTH-1:0] first_row;

  always_comb begin
    em_first  = em_mask & (~em_mask + 1'b1);
    em_rest   = em_mask & ~em_first;
    first_row = '0;
    for (int r = NR - 1; r >= 0; r--) begin
      if (em_mask[r]) begin
        first_row = r[kpd_pkg::ROW_WIDTH-1:0];
      end
    end
  end

  logic [kpd_pkg::KEY_WIDTH-1:0] first_key;
  assign first_key = {em_col, first_row};

  assign key.valid       = em_valid;
  assign key.next_column = em_next;
  assign key.key_valid   = em_mask != '0;
  assign key.key_index   = (em_mask != '0) ? first_key : '0;
  assign key.key_char    = (em_mask != '0) ? kpd_pkg::KEY_MAP[first_key] : '0;
  assign key.last        = em_rest == '0;

  // checks
  a_no_same_row: assert property (@(posedge clk) disable iff (rst)
    (s1_move && scan_accept) |-> (s1_col != scan_column))
    else $error("write-back and read hit the same column");

  a_emitter_refill: assert property (@(posedge clk) disable iff (rst)
    em_done |=> (em_valid == $past(s1_valid)))
    else $error("emitter not refilled from update stage");

  a_column_hold: assert property (@(posedge clk) disable iff (rst)
    !scan_accept |=> $stable(scan_column))
    else $error("column moved without a scan item");

  a_next_column: assert property (@(posedge clk) disable iff (rst)
    em_valid |-> (em_next == em_col + 1'b1))
    else $error("next column out of step with emitter column");

endmodule

`default_nettype wire
